// ===== sv/lstmm_pkg.sv =====
// Shared types and constants of the lazy segment tree with range multiply and range sum.
package lstmm_pkg;

    localparam int LEAVES_DEF = 1024;
    localparam int VW = 30;
    localparam logic [VW-1:0] PRIME = 30'd1000000007;
    localparam logic [VW-1:0] ONE = 30'd1;

    typedef enum logic [1:0] {
        CMD_SET,
        CMD_MUL,
        CMD_SUM,
        CMD_PROD
    } t_cmd;

    typedef struct packed {
        logic [VW-1:0] lz;
        logic [VW-1:0] sum;
    } t_node;

    typedef enum logic [1:0] {
        MODE_PUSH0,
        MODE_PUSH1,
        MODE_RANGE
    } t_mode;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DN_RD,
        S_DN_CHK,
        S_AP_RD,
        S_AP_MUL,
        S_AP_WAIT,
        S_NEXT,
        S_MID_RD,
        S_MID_GET,
        S_LOOP,
        S_ACC,
        S_UP_CHK,
        S_UP_RD0,
        S_UP_RD1,
        S_UP_RD2,
        S_UP_WR,
        S_OUT
    } t_state;

endpackage

// ===== sv/lazy_segment_tree_mulsum_mod.sv =====
// Top level: command sequencer of the lazy segment tree with range multiply and range sum.
//
// A command word is taken when start is high and busy is low. Fields: i_command (set,
// range multiply, range sum, position product), i_first, i_last and i_value. Every
// command gives one result word on o_result, marked by o_valid for exactly one cycle;
// the receiver cannot stall, and busy stays high until that cycle has passed.
// Commands run one at a time. A command walks down the two boundary paths of the
// tree, pushing pending factors, then works on the covered nodes (a set or position
// product on its one leaf) and, for set and range multiply, walks back up. Each node
// that is scaled waits on the serial modular multipliers; other node visits go
// through the single read port of the node store. An empty range or a position
// outside the tree goes straight to the result word. After reset the store is
// cleared, one node a cycle; busy is high during that pass.
module lazy_segment_tree_mulsum_mod #(
    parameter int LEAVES = lstmm_pkg::LEAVES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_command,
    input  logic [9:0]                i_first,
    input  logic [9:0]                i_last,
    input  logic [lstmm_pkg::VW-1:0]  i_value,
    output logic                      o_valid,
    output logic [lstmm_pkg::VW-1:0]  o_result
);

    localparam int LOG = $clog2(LEAVES);
    localparam int SIZE = 2 ** LOG;
    localparam int AW = LOG + 1;
    localparam int IW = $clog2(LOG + 1);
    localparam int VW = lstmm_pkg::VW;

    lstmm_pkg::t_state r_state, n_state;
    lstmm_pkg::t_cmd   r_cmd, n_cmd, in_cmd;
    lstmm_pkg::t_mode  r_mode, n_mode;

    logic [AW-1:0] r_l0, n_l0;
    logic [AW-1:0] r_rm1, n_rm1;
    logic [AW:0]   r_l, n_l;
    logic [AW:0]   r_r, n_r;
    logic [IW-1:0] r_lvl, n_lvl;
    logic          r_side, n_side;
    logic [AW-1:0] r_node, n_node;
    logic [AW-1:0] r_child, n_child;
    logic [AW-1:0] r_clr, n_clr;
    logic [VW-1:0] r_fac, n_fac;
    logic [VW-1:0] r_val, n_val;
    logic [VW-1:0] r_acc, n_acc;
    logic [VW-1:0] r_s0, n_s0;
    logic [VW-1:0] r_s1, n_s1;
    logic [VW-1:0] r_res, n_res;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;
    lstmm_pkg::t_node mem_wdata;
    lstmm_pkg::t_node mem_rdata;

    logic             mul_start;
    logic             mul_done_s, mul_done_l;
    logic [VW-1:0]    mul_sum, mul_lz;

    logic [31:0]   first32, last32, last_sat;
    logic          in_point, in_ok;
    logic [AW-1:0] in_l0, in_rm1;
    logic [VW-1:0] in_val;
    logic [AW-1:0] dn_node;
    logic [AW:0]   lvl_mask, r_end, r_dec;
    logic          up_cond, dn_last, up_last, loop_done;
    lstmm_pkg::t_state mid_state;

    function automatic logic [VW-1:0] mod_add(input logic [VW-1:0] x, input logic [VW-1:0] y);
        logic [VW:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, lstmm_pkg::PRIME}) begin
            s = s - {1'b0, lstmm_pkg::PRIME};
        end
        return s[VW-1:0];
    endfunction

    lstmm_store #(
        .AW(AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    lstmm_modmul u_mul_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mem_rdata.sum),
        .i_b     (r_fac),
        .o_done  (mul_done_s),
        .o_prod  (mul_sum)
    );

    lstmm_modmul u_mul_lz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mem_rdata.lz),
        .i_b     (r_fac),
        .o_done  (mul_done_l),
        .o_prod  (mul_lz)
    );

    always_comb begin
        in_cmd   = lstmm_pkg::t_cmd'(i_command);
        first32  = 32'(i_first);
        last32   = 32'(i_last);
        last_sat = (last32 > 32'(LEAVES - 1)) ? 32'(LEAVES - 1) : last32;
        in_point = (in_cmd == lstmm_pkg::CMD_SET) || (in_cmd == lstmm_pkg::CMD_PROD);
        in_ok    = (first32 < 32'(LEAVES)) && (in_point || (first32 <= last_sat));
        in_l0    = AW'(first32 + 32'(SIZE));
        in_rm1   = in_point ? in_l0 : AW'(last_sat + 32'(SIZE));
        in_val   = (i_value >= lstmm_pkg::PRIME) ? (i_value - lstmm_pkg::PRIME) : i_value;

        dn_node  = (r_side ? r_rm1 : r_l0) >> r_lvl;
        lvl_mask = ~({(AW + 1){1'b1}} << r_lvl);
        r_end    = {1'b0, r_rm1} + 1'b1;
        r_dec    = r_r - 1'b1;
        up_cond  = (r_cmd == lstmm_pkg::CMD_SET) ||
                   (r_side ? ((r_end & lvl_mask) != '0) : (({1'b0, r_l0} & lvl_mask) != '0));
        dn_last  = r_side && (r_lvl == IW'(1));
        up_last  = r_side && (r_lvl == IW'(LOG));
        loop_done = (r_l >= r_r);
        mid_state = ((r_cmd == lstmm_pkg::CMD_SET) || (r_cmd == lstmm_pkg::CMD_PROD)) ?
                    lstmm_pkg::S_MID_RD : lstmm_pkg::S_LOOP;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lstmm_pkg::S_CLEAR: begin
                if (r_clr == {AW{1'b1}}) begin
                    n_state = lstmm_pkg::S_IDLE;
                end
            end
            lstmm_pkg::S_IDLE: begin
                if (start) begin
                    n_state = in_ok ? lstmm_pkg::S_DN_RD : lstmm_pkg::S_OUT;
                end
            end
            lstmm_pkg::S_DN_RD: n_state = lstmm_pkg::S_DN_CHK;
            lstmm_pkg::S_DN_CHK: begin
                if (mem_rdata.lz != lstmm_pkg::ONE) begin
                    n_state = lstmm_pkg::S_AP_RD;
                end else if (dn_last) begin
                    n_state = mid_state;
                end else begin
                    n_state = lstmm_pkg::S_DN_RD;
                end
            end
            lstmm_pkg::S_AP_RD:  n_state = lstmm_pkg::S_AP_MUL;
            lstmm_pkg::S_AP_MUL: n_state = lstmm_pkg::S_AP_WAIT;
            lstmm_pkg::S_AP_WAIT: begin
                if (mul_done_s) begin
                    n_state = lstmm_pkg::S_NEXT;
                end
            end
            lstmm_pkg::S_NEXT: begin
                case (r_mode)
                    lstmm_pkg::MODE_PUSH0: n_state = lstmm_pkg::S_AP_RD;
                    lstmm_pkg::MODE_PUSH1: n_state = dn_last ? mid_state : lstmm_pkg::S_DN_RD;
                    default:               n_state = lstmm_pkg::S_LOOP;
                endcase
            end
            lstmm_pkg::S_MID_RD: n_state = lstmm_pkg::S_MID_GET;
            lstmm_pkg::S_MID_GET: begin
                n_state = (r_cmd == lstmm_pkg::CMD_SET) ? lstmm_pkg::S_UP_CHK : lstmm_pkg::S_OUT;
            end
            lstmm_pkg::S_LOOP: begin
                if (loop_done) begin
                    n_state = (r_cmd == lstmm_pkg::CMD_SUM) ? lstmm_pkg::S_OUT :
                              lstmm_pkg::S_UP_CHK;
                end else if (r_l[0] || r_r[0]) begin
                    n_state = (r_cmd == lstmm_pkg::CMD_SUM) ? lstmm_pkg::S_ACC :
                              lstmm_pkg::S_AP_RD;
                end
            end
            lstmm_pkg::S_ACC: n_state = lstmm_pkg::S_LOOP;
            lstmm_pkg::S_UP_CHK: begin
                if (up_cond) begin
                    n_state = lstmm_pkg::S_UP_RD0;
                end else if (up_last) begin
                    n_state = lstmm_pkg::S_OUT;
                end
            end
            lstmm_pkg::S_UP_RD0: n_state = lstmm_pkg::S_UP_RD1;
            lstmm_pkg::S_UP_RD1: n_state = lstmm_pkg::S_UP_RD2;
            lstmm_pkg::S_UP_RD2: n_state = lstmm_pkg::S_UP_WR;
            lstmm_pkg::S_UP_WR:  n_state = up_last ? lstmm_pkg::S_OUT : lstmm_pkg::S_UP_CHK;
            lstmm_pkg::S_OUT:    n_state = lstmm_pkg::S_IDLE;
            default:             n_state = lstmm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_cmd     = r_cmd;
        n_mode    = r_mode;
        n_l0      = r_l0;
        n_rm1     = r_rm1;
        n_l       = r_l;
        n_r       = r_r;
        n_lvl     = r_lvl;
        n_side    = r_side;
        n_node    = r_node;
        n_child   = r_child;
        n_clr     = r_clr;
        n_fac     = r_fac;
        n_val     = r_val;
        n_acc     = r_acc;
        n_s0      = r_s0;
        n_s1      = r_s1;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_waddr = r_node;
        mem_wdata = mem_rdata;
        mem_raddr = r_node;
        mul_start = 1'b0;
        case (r_state)
            lstmm_pkg::S_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = r_clr;
                mem_wdata.lz  = lstmm_pkg::ONE;
                mem_wdata.sum = '0;
                n_clr         = r_clr + 1'b1;
            end
            lstmm_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd  = in_cmd;
                    n_l0   = in_l0;
                    n_rm1  = in_rm1;
                    n_l    = {1'b0, in_l0};
                    n_r    = {1'b0, in_rm1} + 1'b1;
                    n_val  = in_val;
                    n_acc  = '0;
                    n_res  = '0;
                    n_lvl  = IW'(LOG);
                    n_side = 1'b0;
                end
            end
            lstmm_pkg::S_DN_RD: begin
                mem_raddr = dn_node;
                n_node    = dn_node;
            end
            lstmm_pkg::S_DN_CHK: begin
                if (mem_rdata.lz != lstmm_pkg::ONE) begin
                    mem_we       = 1'b1;
                    mem_wdata.lz = lstmm_pkg::ONE;
                    n_fac        = mem_rdata.lz;
                    n_child      = {r_node[AW-2:0], 1'b0};
                    n_mode       = lstmm_pkg::MODE_PUSH0;
                end else begin
                    n_side = ~r_side;
                    if (r_side) begin
                        n_lvl = r_lvl - 1'b1;
                    end
                end
            end
            lstmm_pkg::S_AP_RD: begin
                mem_raddr = r_child;
            end
            lstmm_pkg::S_AP_MUL: begin
                mul_start = 1'b1;
            end
            lstmm_pkg::S_AP_WAIT: begin
                mem_waddr     = r_child;
                mem_wdata.lz  = mul_lz;
                mem_wdata.sum = mul_sum;
                mem_we        = mul_done_s;
            end
            lstmm_pkg::S_NEXT: begin
                case (r_mode)
                    lstmm_pkg::MODE_PUSH0: begin
                        n_child = r_child + 1'b1;
                        n_mode  = lstmm_pkg::MODE_PUSH1;
                    end
                    lstmm_pkg::MODE_PUSH1: begin
                        n_side = ~r_side;
                        if (r_side) begin
                            n_lvl = r_lvl - 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            lstmm_pkg::S_MID_RD: begin
                mem_raddr = r_l0;
            end
            lstmm_pkg::S_MID_GET: begin
                mem_waddr     = r_l0;
                mem_wdata.sum = r_val;
                mem_we        = (r_cmd == lstmm_pkg::CMD_SET);
                n_res         = (r_cmd == lstmm_pkg::CMD_SET) ? '0 : mem_rdata.lz;
                n_lvl         = IW'(1);
                n_side        = 1'b0;
            end
            lstmm_pkg::S_LOOP: begin
                n_fac  = r_val;
                n_mode = lstmm_pkg::MODE_RANGE;
                if (loop_done) begin
                    n_res  = (r_cmd == lstmm_pkg::CMD_SUM) ? r_acc : '0;
                    n_lvl  = IW'(1);
                    n_side = 1'b0;
                end else if (r_l[0]) begin
                    mem_raddr = r_l[AW-1:0];
                    n_child   = r_l[AW-1:0];
                    n_l       = r_l + 1'b1;
                end else if (r_r[0]) begin
                    mem_raddr = r_dec[AW-1:0];
                    n_child   = r_dec[AW-1:0];
                    n_r       = r_dec;
                end else begin
                    n_l = r_l >> 1;
                    n_r = r_r >> 1;
                end
            end
            lstmm_pkg::S_ACC: begin
                n_acc = mod_add(r_acc, mem_rdata.sum);
            end
            lstmm_pkg::S_UP_CHK: begin
                n_node = dn_node;
                if (!up_cond) begin
                    n_side = ~r_side;
                    if (r_side) begin
                        n_lvl = r_lvl + 1'b1;
                    end
                end
            end
            lstmm_pkg::S_UP_RD0: begin
                mem_raddr = {r_node[AW-2:0], 1'b0};
            end
            lstmm_pkg::S_UP_RD1: begin
                mem_raddr = {r_node[AW-2:0], 1'b1};
                n_s0      = mem_rdata.sum;
            end
            lstmm_pkg::S_UP_RD2: begin
                mem_raddr = r_node;
                n_s1      = mem_rdata.sum;
            end
            lstmm_pkg::S_UP_WR: begin
                mem_we        = 1'b1;
                mem_wdata.sum = mod_add(r_s0, r_s1);
                n_side        = ~r_side;
                if (r_side) begin
                    n_lvl = r_lvl + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lstmm_pkg::S_CLEAR;
            r_clr   <= '0;
            r_mode  <= lstmm_pkg::MODE_PUSH0;
            r_lvl   <= '0;
            r_side  <= 1'b0;
            r_cmd   <= lstmm_pkg::CMD_SET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_mode  <= n_mode;
            r_lvl   <= n_lvl;
            r_side  <= n_side;
            r_cmd   <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l0    <= n_l0;
        r_rm1   <= n_rm1;
        r_l     <= n_l;
        r_r     <= n_r;
        r_node  <= n_node;
        r_child <= n_child;
        r_fac   <= n_fac;
        r_val   <= n_val;
        r_acc   <= n_acc;
        r_s0    <= n_s0;
        r_s1    <= n_s1;
        r_res   <= n_res;
    end

    assign busy     = (r_state != lstmm_pkg::S_IDLE);
    assign o_valid  = (r_state == lstmm_pkg::S_OUT);
    assign o_result = r_res;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_mul_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done_s == mul_done_l)
        else $error("modular multipliers out of step");

    a_update_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_cmd == lstmm_pkg::CMD_SET || r_cmd == lstmm_pkg::CMD_MUL))
        |-> (o_result == '0))
        else $error("update command returned a non-zero word");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result < lstmm_pkg::PRIME))
        else $error("result not reduced modulo the prime");

endmodule

// ===== sv/lstmm_modmul.sv =====
// Serial modular multiplier, two multiplier bits per cycle, result modulo the prime.
module lstmm_modmul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lstmm_pkg::VW-1:0]  i_a,
    input  logic [lstmm_pkg::VW-1:0]  i_b,
    output logic                      o_done,
    output logic [lstmm_pkg::VW-1:0]  o_prod
);

    localparam int STEPS = lstmm_pkg::VW / 2;
    localparam int CW = $clog2(STEPS + 1);
    localparam logic [31:0] P1 = {2'b00, lstmm_pkg::PRIME};
    localparam logic [31:0] P2 = {1'b0, lstmm_pkg::PRIME, 1'b0};

    logic [lstmm_pkg::VW-1:0] r_acc, n_acc;
    logic [lstmm_pkg::VW-1:0] r_a;
    logic [lstmm_pkg::VW-1:0] r_b;
    logic [CW-1:0]            r_cnt;
    logic                     r_run;
    logic                     r_done;

    function automatic logic [lstmm_pkg::VW-1:0] mm_step(
        input logic [lstmm_pkg::VW-1:0] acc,
        input logic [lstmm_pkg::VW-1:0] a,
        input logic                     b_in
    );
        logic [31:0] t;
        t = {1'b0, acc, 1'b0} + (b_in ? {2'b00, a} : 32'd0);
        if (t >= P2) begin
            t = t - P2;
        end else if (t >= P1) begin
            t = t - P1;
        end
        return t[lstmm_pkg::VW-1:0];
    endfunction

    always_comb begin
        n_acc = mm_step(mm_step(r_acc, r_a, r_b[lstmm_pkg::VW-1]), r_a, r_b[lstmm_pkg::VW-2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(STEPS);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_run) begin
            r_acc <= n_acc;
            r_b   <= {r_b[lstmm_pkg::VW-3:0], 2'b00};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== sv/lstmm_store.sv =====
// Node store: one write port and one read port with registered read data.
module lstmm_store #(
    parameter int AW = 11
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  lstmm_pkg::t_node    i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output lstmm_pkg::t_node    o_rdata
);

    localparam int DEPTH = 2 ** AW;

    lstmm_pkg::t_node r_mem [DEPTH];
    lstmm_pkg::t_node r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== verif/tb_lazy_segment_tree_mulsum_mod.sv =====
// Testbench of the lazy segment tree, checked against a flat per-position model.
`timescale 1ns / 100ps

module tb_lazy_segment_tree_mulsum_mod;

    localparam int NPOS = 1024;
    localparam int VW = lstmm_pkg::VW;
    localparam longint unsigned MODP = 64'd1000000007;

    typedef struct {
        lstmm_pkg::t_cmd cmd;
        logic [9:0]      first;
        logic [9:0]      last;
        logic [VW-1:0]   value;
        bit              drain;
    } t_word;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    logic [1:0]      i_command = '0;
    logic [9:0]      i_first = '0;
    logic [9:0]      i_last = '0;
    logic [VW-1:0]   i_value = '0;
    logic            o_valid;
    logic [VW-1:0]   o_result;

    t_word           pending_words[$];
    logic [VW-1:0]   expected_results[$];
    logic [VW-1:0]   pos_value[NPOS];
    logic [VW-1:0]   pos_factor[NPOS];
    int              idle_pct = 7;
    int              n_errors = 0;
    bit              draining = 1'b0;

    lazy_segment_tree_mulsum_mod u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_first(i_first), .i_last(i_last), .i_value(i_value),
        .o_valid(o_valid), .o_result(o_result)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [VW-1:0] mulmod(logic [VW-1:0] a, logic [VW-1:0] b);
        longint unsigned p;
        p = (longint'(a) * longint'(b)) % MODP;
        return p[VW-1:0];
    endfunction

    function automatic logic [VW-1:0] tree_apply(t_word w);
        logic [VW-1:0]   v;
        longint unsigned acc;
        int              hi;
        v = VW'(longint'(w.value) % MODP);
        hi = int'(w.last);
        acc = 0;
        case (w.cmd)
            lstmm_pkg::CMD_SET: pos_value[w.first] = v;
            lstmm_pkg::CMD_MUL: begin
                for (int i = int'(w.first); i <= hi; i++) begin
                    pos_value[i] = mulmod(pos_value[i], v);
                    pos_factor[i] = mulmod(pos_factor[i], v);
                end
            end
            lstmm_pkg::CMD_SUM: begin
                for (int i = int'(w.first); i <= hi; i++)
                    acc = (acc + 64'(pos_value[i])) % MODP;
            end
            default: acc = 64'(pos_factor[w.first]);
        endcase
        return acc[VW-1:0];
    endfunction

    function automatic t_word make_word(lstmm_pkg::t_cmd c, int f, int l, logic [VW-1:0] v);
        t_word w;
        w.cmd = c;
        w.first = f[9:0];
        w.last = l[9:0];
        w.value = v;
        w.drain = 1'b0;
        return w;
    endfunction

    function automatic void add_word(t_word w);
        pending_words = {pending_words, w};
    endfunction

    function automatic t_word random_word();
        int              f;
        int              l;
        int              span;
        logic [VW-1:0]   v;
        lstmm_pkg::t_cmd c;
        c = lstmm_pkg::t_cmd'($urandom_range(3, 0));
        f = $urandom_range(NPOS - 1, 0);
        case ($urandom_range(9, 0))
            0: l = $urandom_range(NPOS - 1, 0);
            1: begin
                f = $urandom_range(15, 0);
                l = $urandom_range(NPOS - 1, NPOS - 16);
            end
            2: l = (f > 0) ? $urandom_range(f - 1, 0) : 0;
            default: begin
                span = $urandom_range(40, 0);
                l = (f + span > NPOS - 1) ? NPOS - 1 : f + span;
            end
        endcase
        v = ($urandom_range(7, 0) == 0) ? VW'($urandom()) : VW'($urandom_range(1000000006, 0));
        if ($urandom_range(3, 0) == 0 && c != lstmm_pkg::CMD_SET)
            c = lstmm_pkg::CMD_SET;
        return make_word(c, f, l, v);
    endfunction

    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                w.cmd = lstmm_pkg::t_cmd'(i_command);
                w.first = i_first;
                w.last = i_last;
                w.value = i_value;
                expected_results = {expected_results, tree_apply(w)};
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (pending_words.size() == 0) begin
                start <= 1'b0;
            end else if (pending_words[0].drain) begin
                start <= 1'b0;
                if (expected_results.size() == 0 && !(start && !busy))
                    void'(pending_words.pop_front());
            end else if ($urandom_range(99, 0) < idle_pct) begin
                start <= 1'b0;
            end else begin
                w = pending_words.pop_front();
                start <= 1'b1;
                i_command <= w.cmd;
                i_first <= w.first;
                i_last <= w.last;
                i_value <= w.value;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %0d", $time, o_result);
                n_errors++;
            end else begin
                if (o_result !== expected_results[0]) begin
                    $display("%0t: result mismatch, expected %0d, actual %0d",
                             $time, expected_results[0], o_result);
                    n_errors++;
                end
                void'(expected_results.pop_front());
            end
        end
    end

    initial begin
        t_word d;
        for (int i = 0; i < NPOS; i++) begin
            pos_value[i] = '0;
            pos_factor[i] = VW'(1);
        end
        d = make_word(lstmm_pkg::CMD_SET, 0, 0, '0);
        d.drain = 1'b1;
        add_word(make_word(lstmm_pkg::CMD_SUM, 0, NPOS - 1, '0));
        add_word(make_word(lstmm_pkg::CMD_PROD, NPOS - 1, 0, '0));
        add_word(make_word(lstmm_pkg::CMD_SET, 0, 0, 30'h3FFF_FFFF));
        add_word(make_word(lstmm_pkg::CMD_SET, NPOS - 1, 0, 30'd1000000006));
        add_word(make_word(lstmm_pkg::CMD_SET, 512, 0, 30'd1000000007));
        add_word(make_word(lstmm_pkg::CMD_SET, 511, 0, 30'd123456789));
        add_word(make_word(lstmm_pkg::CMD_MUL, 0, NPOS - 1, 30'd1000000006));
        add_word(make_word(lstmm_pkg::CMD_SUM, 0, NPOS - 1, '0));
        add_word(make_word(lstmm_pkg::CMD_MUL, 300, 700, 30'h2AAA_AAAA));
        add_word(make_word(lstmm_pkg::CMD_SUM, 511, 512, '0));
        add_word(make_word(lstmm_pkg::CMD_SET, 512, 0, 30'd5));
        add_word(make_word(lstmm_pkg::CMD_PROD, 512, 0, '0));
        add_word(make_word(lstmm_pkg::CMD_SUM, 512, 512, '0));
        add_word(make_word(lstmm_pkg::CMD_MUL, 700, 300, 30'd7));
        add_word(make_word(lstmm_pkg::CMD_SUM, 700, 300, '0));
        add_word(make_word(lstmm_pkg::CMD_MUL, 1, 1, 30'd1));
        add_word(make_word(lstmm_pkg::CMD_PROD, 0, 0, '0));
        add_word(d);
        add_word(make_word(lstmm_pkg::CMD_MUL, 0, 0, '0));
        add_word(make_word(lstmm_pkg::CMD_PROD, 0, 0, '0));
        add_word(make_word(lstmm_pkg::CMD_SUM, 0, NPOS - 1, '0));
        add_word(make_word(lstmm_pkg::CMD_PROD, NPOS - 1, NPOS - 1, '0));
        for (int i = 0; i < 530; i++) begin
            if (i % 100 == 50)
                add_word(d);
            add_word(random_word());
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_words.size() > 360) @(posedge i_clk);
        idle_pct = 60;
        while (pending_words.size() > 180) @(posedge i_clk);
        idle_pct = 0;
        while (pending_words.size() > 0 || start) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #40ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
